/* design/fcfs_pkg.sv */
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared types and codes for the FCFS batch job admission block.
// ----------------------------------------------------------------------------
package fcfs_pkg;

   localparam int NUM_RES = 3;

   // result kinds
   localparam logic [1:0] EV_ACCEPT = 2'd0;
   localparam logic [1:0] EV_REJECT = 2'd1;
   localparam logic [1:0] EV_ADMIT  = 2'd2;
   localparam logic [1:0] EV_FINISH = 2'd3;

   // classified command handed from front to back
   typedef struct packed {
      logic                         is_tick;
      logic                         cap_ok;
      logic [15:0]                  need_time;
      logic [NUM_RES-1:0][7:0]      res;
      logic [31:0]                  arrival;
   } cmd_type;

   // waiting job
   typedef struct packed {
      logic [15:0]                  need_time;
      logic [NUM_RES-1:0][7:0]      res;
      logic [31:0]                  arrival;
      logic [15:0]                  id;
   } job_type;

   // running job
   typedef struct packed {
      logic [15:0]                  need_time;
      logic [NUM_RES-1:0][7:0]      res;
      logic [31:0]                  start;
      logic [15:0]                  id;
   } run_type;

   // one result
   typedef struct packed {
      logic [1:0]                   kind;
      logic [15:0]                  id;
      logic [31:0]                  stamp;
   } evt_type;

endpackage

/* design/fcfs_batch_job_admission.sv */
// ----------------------------------------------------------------------------
// fcfs_batch_job_admission
// FCFS batch scheduler with three-resource admission control.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req_     in   tvalid/tready      tuser=func, tdata=job fields
//  rsp_     out  tvalid/tready      tuser=event kind, tdata=id/time, tlast
//  csr_     in   we                 addr=register index, wdata
//
//  A submit transaction is executed by the back end in its idle state, then
//  handed to the output. A tick passes through command pop and head read,
//  admit, a finish scan over the run-table entries that is closed once the
//  last entry is passed, and a flush of the last result.
//  Reset is synchronous; the wait queue itself is not cleared.
//  A 2-deep command queue decouples the request side from the back end;
//  rsp stalls hold the back end only when a new result must go out.
// ----------------------------------------------------------------------------
module fcfs_batch_job_admission #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_RUN     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // need_time, res_a, res_b, res_c, arrival_time
   input  logic         req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // job_id, event_time
   output logic [1:0]   rsp_tuser,   // event_res
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [7:0]   csr_wdata
);
   import fcfs_pkg::*;

   localparam logic [1:0] REG_LIMIT = 2'd0;
   localparam logic [1:0] REG_CAP_A = 2'd1;
   localparam logic [1:0] REG_CAP_B = 2'd2;
   localparam logic [1:0] REG_CAP_C = 2'd3;

   logic [3:0] limit_ff;
   logic [7:0] cap_a_ff, cap_b_ff, cap_c_ff;
   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 4'd1;
         cap_a_ff <= 8'd16;
         cap_b_ff <= 8'd6;
         cap_c_ff <= 8'd9;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_LIMIT: limit_ff <= csr_wdata[3:0];
            REG_CAP_A: cap_a_ff <= csr_wdata;
            REG_CAP_B: cap_b_ff <= csr_wdata;
            REG_CAP_C: cap_c_ff <= csr_wdata;
            default:   limit_ff <= limit_ff;
         endcase
      end
   end

   fcfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cap_a      (cap_a_ff),
      .cap_b      (cap_b_ff),
      .cap_c      (cap_c_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   fcfs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_RUN     (MAX_RUN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .limit      (limit_ff),
      .cap_a      (cap_a_ff),
      .cap_b      (cap_b_ff),
      .cap_c      (cap_c_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/fcfs_front.sv */
// ----------------------------------------------------------------------------
// fcfs_front
// Accepts request transactions, checks capacities, queues commands (2 deep).
// ----------------------------------------------------------------------------
module fcfs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [71:0]         req_tdata,
   input  logic                req_tuser,
   input  logic [7:0]          cap_a,
   input  logic [7:0]          cap_b,
   input  logic [7:0]          cap_c,
   output logic                cmd_valid,
   output fcfs_pkg::cmd_type   cmd,
   input  logic                cmd_pop
);
   import fcfs_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push;

   always_comb begin
      dec.is_tick   = req_tuser;
      dec.need_time = req_tdata[15:0];
      dec.res[0]    = req_tdata[23:16];
      dec.res[1]    = req_tdata[31:24];
      dec.res[2]    = req_tdata[39:32];
      dec.arrival   = req_tdata[71:40];
      dec.cap_ok    = (req_tdata[23:16] <= cap_a) && (req_tdata[31:24] <= cap_b) &&
                      (req_tdata[39:32] <= cap_c);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

endmodule

/* design/fcfs_back.sv */
// ----------------------------------------------------------------------------
// fcfs_back
// Executes commands: wait queue, admission, time advance, finish scan.
// ----------------------------------------------------------------------------
module fcfs_back #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_RUN     = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  fcfs_pkg::cmd_type   cmd,
   output logic                cmd_pop,
   input  logic [3:0]          limit,
   input  logic [7:0]          cap_a,
   input  logic [7:0]          cap_b,
   input  logic [7:0]          cap_c,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import fcfs_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int RW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam int NW = $clog2(MAX_RUN + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ADMIT = 4'b0010,
      S_SCAN  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   job_type              mem [QUEUE_DEPTH];
   job_type              q_rd_ff;
   logic                 mem_we;
   logic [QW-1:0]        mem_waddr;
   job_type              mem_wdata;
   logic [QW-1:0]        head_ff, head_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   run_type              run_ff [MAX_RUN];
   run_type              run_in [MAX_RUN];
   logic [NW-1:0]        run_cnt_ff, run_cnt_in;
   logic [NW-1:0]        idx_ff, idx_in;
   logic [2:0][7:0]      used_ff, used_in;
   logic [31:0]          time_ff, time_in;
   logic [15:0]          next_id_ff, next_id_in;
   logic                 pend_valid_ff, pend_valid_in;
   evt_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   evt_type              out_ff, out_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_free, ok, admit, fit;
   logic [2:0][7:0]      cap;
   logic [7:0]           free_units;
   logic [SW-1:0]        tail_sum;
   logic [5:0]           lim6;
   run_type              cur;

   assign cap = {cap_c, cap_b, cap_a};
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      run_in        = run_ff;
      run_cnt_in    = run_cnt_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      time_in       = time_ff;
      next_id_in    = next_id_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      ok            = 1'b0;
      admit         = 1'b0;
      fit           = 1'b1;
      free_units    = 8'd0;
      cur           = run_ff[idx_ff[RW-1:0]];

      tail_sum = SW'(head_ff) + SW'(cnt_ff);
      if (tail_sum >= SW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SW'(QUEUE_DEPTH);
      end
      mem_waddr           = tail_sum[QW-1:0];
      mem_wdata.need_time = cmd.need_time;
      mem_wdata.res       = cmd.res;
      mem_wdata.arrival   = cmd.arrival;
      mem_wdata.id        = next_id_ff;

      lim6 = ({2'b00, limit} > 6'(MAX_RUN)) ? 6'(MAX_RUN) : {2'b00, limit};

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (!cmd.is_tick) begin
                  if (out_free) begin
                     cmd_pop      = 1'b1;
                     ok           = (cnt_ff < CW'(QUEUE_DEPTH)) &&
                                    (cmd.need_time != 16'd0) && cmd.cap_ok;
                     rsp_valid_in = 1'b1;
                     out_in.kind  = ok ? EV_ACCEPT : EV_REJECT;
                     out_in.id    = ok ? next_id_ff : 16'd0;
                     out_in.stamp = time_ff;
                     out_last_in  = 1'b1;
                     if (ok) begin
                        mem_we     = 1'b1;
                        cnt_in     = cnt_ff + 1'b1;
                        next_id_in = next_id_ff + 16'd1;
                     end
                  end
               end else begin
                  cmd_pop  = 1'b1;
                  state_in = S_ADMIT;
               end
            end
         end
         S_ADMIT: begin
            for (int r = 0; r < NUM_RES; r++) begin
               free_units = (cap[r] > used_ff[r]) ? cap[r] - used_ff[r] : 8'd0;
               if (q_rd_ff.res[r] > free_units) begin
                  fit = 1'b0;
               end
            end
            admit = (cnt_ff != '0) && (q_rd_ff.arrival <= time_ff) && fit &&
                    (6'(run_cnt_ff) < lim6);
            if (admit) begin
               run_in[run_cnt_ff[RW-1:0]].need_time = q_rd_ff.need_time;
               run_in[run_cnt_ff[RW-1:0]].res       = q_rd_ff.res;
               run_in[run_cnt_ff[RW-1:0]].start     = time_ff;
               run_in[run_cnt_ff[RW-1:0]].id        = q_rd_ff.id;
               run_cnt_in = run_cnt_ff + 1'b1;
               for (int r = 0; r < NUM_RES; r++) begin
                  used_in[r] = used_ff[r] + q_rd_ff.res[r];
               end
               head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               cnt_in  = cnt_ff - 1'b1;
               pend_valid_in = 1'b1;
               pend_in.kind  = EV_ADMIT;
               pend_in.id    = q_rd_ff.id;
               pend_in.stamp = time_ff;
            end
            time_in  = time_ff + 32'd1;
            idx_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (idx_ff < run_cnt_ff) begin
               if ((time_ff - cur.start) == {16'd0, cur.need_time}) begin
                  if (!pend_valid_ff || out_free) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        out_in       = pend_ff;
                        out_last_in  = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_in.kind  = EV_FINISH;
                     pend_in.id    = cur.id;
                     pend_in.stamp = time_ff;
                     for (int m = 0; m < MAX_RUN - 1; m++) begin
                        if (NW'(m) >= idx_ff) begin
                           run_in[m] = run_ff[m + 1];
                        end
                     end
                     run_cnt_in = run_cnt_ff - 1'b1;
                     for (int r = 0; r < NUM_RES; r++) begin
                        used_in[r] = used_ff[r] - cur.res[r];
                     end
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         cnt_ff        <= '0;
         run_cnt_ff    <= '0;
         idx_ff        <= '0;
         used_ff       <= '0;
         time_ff       <= '0;
         next_id_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         cnt_ff        <= cnt_in;
         run_cnt_ff    <= run_cnt_in;
         idx_ff        <= idx_in;
         used_ff       <= used_in;
         time_ff       <= time_in;
         next_id_ff    <= next_id_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // wait queue storage, registered read of the head entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      q_rd_ff <= mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_ff.stamp, out_ff.id};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_cnt_ff <= NW'(MAX_RUN))
      else $error("running set overflow");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("wait queue overflow");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("pending result left behind");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADMIT |=> time_ff == $past(time_ff) + 32'd1)
      else $error("tick did not advance time");

endmodule

/* dv/fcfs_batch_job_admission_check.sv */
// ----------------------------------------------------------------------------
// fcfs_batch_job_admission_check
// Watches the request, result and register channels of the FCFS admission
// block, keeps its own scheduler state and checks each result transaction.
// ----------------------------------------------------------------------------
package fcfs_tb_pkg;

   localparam logic FUNC_SUBMIT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   localparam logic [1:0] REG_LIMIT = 2'd0;
   localparam logic [1:0] REG_CAP_A = 2'd1;
   localparam logic [1:0] REG_CAP_B = 2'd2;
   localparam logic [1:0] REG_CAP_C = 2'd3;

endpackage

module fcfs_batch_job_admission_check
   import fcfs_pkg::*;
   import fcfs_tb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_RUN     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [7:0]   csr_wdata,
   output int           errors,
   output int           pending
);

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] id;
      logic [31:0] stamp;
      logic        last;
   } event_exp_t;

   event_exp_t  event_q[$];

   job_type     wait_jobs[QUEUE_DEPTH];
   int          wait_head, wait_count;
   run_type     running[MAX_RUN];
   int          run_count;
   int          used_units[NUM_RES];
   logic [31:0] now_tick;
   logic [15:0] next_id;
   logic [3:0]  run_limit;
   logic [7:0]  cap[NUM_RES];

   function automatic void post_event(logic [1:0] kind, logic [15:0] id, logic [31:0] stamp);
      event_exp_t e;
      e.kind  = kind;
      e.id    = id;
      e.stamp = stamp;
      e.last  = 1'b0;
      event_q.push_back(e);
   endfunction

   function automatic void predict_schedule(logic func, logic [71:0] data);
      job_type j;
      logic    ok;
      int      n0, lim, i, m;
      n0 = event_q.size();
      if (func == FUNC_SUBMIT) begin
         j.need_time = data[15:0];
         j.res[0]    = data[23:16];
         j.res[1]    = data[31:24];
         j.res[2]    = data[39:32];
         j.arrival   = data[71:40];
         j.id        = next_id;
         ok = (wait_count < QUEUE_DEPTH) && (j.need_time != 0);
         for (int r = 0; r < NUM_RES; r++)
            if (j.res[r] > cap[r]) ok = 1'b0;
         if (ok) begin
            wait_jobs[(wait_head + wait_count) % QUEUE_DEPTH] = j;
            wait_count++;
            next_id = next_id + 16'd1;
            post_event(EV_ACCEPT, j.id, now_tick);
         end else begin
            post_event(EV_REJECT, 16'd0, now_tick);
         end
      end else begin
         // head admission, before time moves
         if (wait_count > 0) begin
            j   = wait_jobs[wait_head];
            lim = (run_limit < MAX_RUN) ? run_limit : MAX_RUN;
            ok  = (j.arrival <= now_tick) && (run_count < lim);
            for (int r = 0; r < NUM_RES; r++)
               if (int'(j.res[r]) > ((cap[r] > used_units[r]) ? cap[r] - used_units[r] : 0))
                  ok = 1'b0;
            if (ok) begin
               running[run_count].need_time = j.need_time;
               running[run_count].res       = j.res;
               running[run_count].start     = now_tick;
               running[run_count].id        = j.id;
               for (int r = 0; r < NUM_RES; r++) used_units[r] += j.res[r];
               run_count++;
               wait_head  = (wait_head + 1) % QUEUE_DEPTH;
               wait_count--;
               post_event(EV_ADMIT, j.id, now_tick);
            end
         end
         now_tick = now_tick + 32'd1;
         // finish scan, admission order kept
         i = 0;
         while (i < run_count) begin
            if (now_tick - running[i].start == {16'd0, running[i].need_time}) begin
               for (int r = 0; r < NUM_RES; r++) used_units[r] -= running[i].res[r];
               post_event(EV_FINISH, running[i].id, now_tick);
               for (m = i; m + 1 < run_count; m++) running[m] = running[m + 1];
               run_count--;
            end else begin
               i++;
            end
         end
      end
      if (event_q.size() > n0) event_q[event_q.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      event_exp_t e;
      if (reset) begin
         event_q.delete();
         wait_head  = 0;
         wait_count = 0;
         run_count  = 0;
         for (int r = 0; r < NUM_RES; r++) used_units[r] = 0;
         now_tick   = '0;
         next_id    = '0;
         run_limit  = 4'd1;
         cap[0]     = 8'd16;
         cap[1]     = 8'd6;
         cap[2]     = 8'd9;
         errors     = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_LIMIT: run_limit = csr_wdata[3:0];
               REG_CAP_A: cap[0] = csr_wdata;
               REG_CAP_B: cap[1] = csr_wdata;
               REG_CAP_C: cap[2] = csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) predict_schedule(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (event_q.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("unexpected result: kind %0d id %0d time %0d last %0b",
                           rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tlast);
            end else begin
               e = event_q.pop_front();
               if (rsp_tuser !== e.kind || rsp_tdata[15:0] !== e.id ||
                   rsp_tdata[47:16] !== e.stamp || rsp_tlast !== e.last) begin
                  errors = errors + 1;
                  if (errors <= 10)
                     $display("mismatch: exp kind %0d id %0d time %0d last %0b, %s",
                              e.kind, e.id, e.stamp, e.last,
                              $sformatf("got %0d %0d %0d %0b", rsp_tuser,
                                        rsp_tdata[15:0], rsp_tdata[47:16], rsp_tlast));
               end
            end
         end
      end
      pending <= event_q.size();
   end

endmodule

/* dv/fcfs_batch_job_admission_test.sv */
// ----------------------------------------------------------------------------
// fcfs_batch_job_admission_test
// Drives submits and ticks into the FCFS admission block under several
// register settings, with random gaps and stalls; the checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module fcfs_batch_job_admission_test;
   import fcfs_pkg::*;
   import fcfs_tb_pkg::*;

   localparam int IDLE_LIMIT   = 5000;  // watchdog: cycles with no transaction
   localparam int DRAIN_CYCLES = 30;    // tick may still scan after last result
   localparam int HOLD_CYCLES  = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;  // need_time, res_a, res_b, res_c, arrival_time
   logic         req_tuser = 1'b0; // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;        // job_id, event_time
   logic [1:0]   rsp_tuser;        // event_res
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [7:0]   csr_wdata = '0;

   int           errors, pending;
   int           idle_cycles;
   int           tick_count;      // mirrors the block's current time
   bit           hold_req;        // asks the receiver for a long hold-off
   bit           no_gaps;         // sender burst mode
   logic [7:0]   cur_cap[NUM_RES];

   always #5 clock = ~clock;

   fcfs_batch_job_admission u_dut (.*);

   fcfs_batch_job_admission_check u_chk (.*);

   // watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver: random stalls, occasional long ready stretches, one hold-off
   initial begin
      int r;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            rsp_tready <= 1'b1;
            repeat (60) @(posedge clock);
         end else if (r < 60) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // one transaction, then an optional gap
   task automatic send(logic func, logic [15:0] need, logic [7:0] a, logic [7:0] b,
                       logic [7:0] c, logic [31:0] arr);
      int n;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {arr, c, b, a, need};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_TICK) tick_count++;
      n = no_gaps ? 0 : pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic tick();
      send(FUNC_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
   endtask

   // wait for all results plus the tail of a quiet tick
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [3:0] lim, logic [7:0] a, logic [7:0] b, logic [7:0] c);
      logic [7:0] vals[4];
      wait_idle();
      vals = '{{4'd0, lim}, a, b, c};
      cur_cap[0] = a;
      cur_cap[1] = b;
      cur_cap[2] = c;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= (i == 0) ? REG_LIMIT : (i == 1) ? REG_CAP_A :
                      (i == 2) ? REG_CAP_B : REG_CAP_C;
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // mostly admissible jobs arriving near the current tick
   task automatic random_job();
      logic [15:0] need;
      logic [7:0]  res[NUM_RES];
      logic [31:0] arr;
      int          r;
      r = $urandom_range(0, 99);
      need = (r < 3) ? 16'($urandom) : (r < 8) ? 16'd0 : 16'($urandom_range(1, 8));
      for (int i = 0; i < NUM_RES; i++)
         res[i] = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, cur_cap[i] / 3))
                                               : 8'($urandom);
      arr = 32'(tick_count) + $urandom_range(0, 4);
      // far arrivals only on jobs that get rejected
      if (need == 0 && $urandom_range(0, 1)) arr = $urandom;
      send(FUNC_SUBMIT, need, res[0], res[1], res[2], arr);
   endtask

   task automatic random_mix(int count);
      for (int k = 0; k < count; k++)
         if ($urandom_range(0, 99) < 55) random_job();
         else tick();
   endtask

   initial begin
      cur_cap[0] = 8'd16;
      cur_cap[1] = 8'd6;
      cur_cap[2] = 8'd9;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings
      send(FUNC_SUBMIT, 16'd0, 8'd1, 8'd1, 8'd1, 32'd0);           // zero run time
      send(FUNC_SUBMIT, 16'd2, 8'd17, 8'd0, 8'd0, 32'd0);          // over cap A
      send(FUNC_SUBMIT, 16'd2, 8'd0, 8'd7, 8'd0, 32'd0);           // over cap B
      send(FUNC_SUBMIT, 16'd2, 8'd0, 8'd0, 8'd10, 32'd0);          // over cap C
      send(FUNC_SUBMIT, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send(FUNC_SUBMIT, 16'd3, 8'd16, 8'd6, 8'd9, 32'd0);          // exact capacity
      send(FUNC_SUBMIT, 16'd1, 8'd1, 8'd0, 8'd0, 32'd5);           // arrives later
      send(FUNC_SUBMIT, 16'd2, 8'd0, 8'd0, 8'd0, 32'd0);
      send(FUNC_TICK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      repeat (8) tick();                                           // admit and finish same tick

      // wide limits and full capacities
      set_config(4'd8, 8'd255, 8'd255, 8'd255);
      send(FUNC_SUBMIT, 16'd1, 8'd255, 8'd255, 8'd255, 32'd0);
      send(FUNC_SUBMIT, 16'd4, 8'd1, 8'd1, 8'd1, 32'd0);           // blocked behind the full job
      repeat (4) tick();

      // limit zero: queue fills, overflow is rejected, ticks are quiet
      set_config(4'd0, 8'd255, 8'd255, 8'd255);
      for (int k = 0; k < 18; k++)
         send(FUNC_SUBMIT, 16'($urandom_range(1, 3)), 8'($urandom_range(0, 60)),
              8'($urandom_range(1, 60)), 8'($urandom_range(0, 60)), 32'd0);
      repeat (3) tick();

      // head blocked by a lowered capacity
      set_config(4'd15, 8'd255, 8'd0, 8'd255);
      repeat (3) tick();
      set_config(4'd15, 8'd255, 8'd255, 8'd255);
      random_mix(40);

      // full-pipeline pressure: receiver holds off, sender never pauses
      hold_req = 1'b1;
      no_gaps  = 1'b1;
      repeat (30) random_job();
      no_gaps  = 1'b0;
      wait_idle();                                                 // sender waits for all results

      set_config(4'd3, 8'd40, 8'd20, 8'd30);
      random_mix(30);
      set_config(4'd8, 8'd16, 8'd6, 8'd9);
      no_gaps = 1'b1;
      random_mix(30);
      no_gaps = 1'b0;
      set_config(4'd1, 8'd0, 8'd255, 8'd128);
      random_mix(30);
      set_config(4'd6, 8'd200, 8'd100, 8'd150);
      random_mix(15);

      wait_idle();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
